// ===== hdl/ordered_list_store_assert.svh =====
// assertion helpers shared by the list store modules
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH

// same-cycle implication
`define OLS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OLS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ols_pkg.sv =====
package ols_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int KIND_W       = 3;
  localparam int POS_W        = 4;
  localparam int STATUS_W     = 2;
  localparam int CNT_OUT_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND    = 3'd0,
    K_INSERT    = 3'd1,
    K_DEL_FIRST = 3'd2,
    K_DEL_ALL   = 3'd3,
    K_READ      = 3'd4,
    K_WRITE     = 3'd5,
    K_SORT      = 3'd6
  } kind_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_PURGE,
    S_SORT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic ptr_clr;
    logic ptr_inc;
    logic append;
    logic insert;
    logic remove;
    logic write;
    logic read;
    logic sort_step;
    logic set_full;
    logic set_not_found;
    logic set_bad;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              at_end;
    logic              hit_gt;
    logic              hit_eq;
    logic              bad_pos;
    logic              none_removed;
  } dp_status_t;

endpackage

// ===== hdl/ols_datapath.sv =====
`include "ordered_list_store_assert.svh"

module ols_datapath #(
  parameter int CAPACITY = ols_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [ols_pkg::KIND_W-1:0]           in_kind,
  input  logic signed [ols_pkg::DATA_W-1:0]    in_value,
  input  logic [ols_pkg::POS_W-1:0]            in_position,
  input  ols_pkg::dp_cmd_t                     cmd,
  output ols_pkg::dp_status_t                  st,
  output logic [ols_pkg::STATUS_W-1:0]         out_status,
  output logic signed [ols_pkg::DATA_W-1:0]    out_read_value,
  output logic [ols_pkg::CNT_OUT_W-1:0]        out_entry_count,
  output logic [ols_pkg::CNT_OUT_W-1:0]        out_removed_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > ols_pkg::POS_W) ? CW : ols_pkg::POS_W;
  localparam int XW = (CW > ols_pkg::CNT_OUT_W) ? CW : ols_pkg::CNT_OUT_W;

  logic signed [ols_pkg::DATA_W-1:0] cells_r   [CAPACITY];
  logic signed [ols_pkg::DATA_W-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]                     count_r;
  logic [CW-1:0]                     ptr_r;
  logic [CW-1:0]                     removed_r;
  logic [ols_pkg::KIND_W-1:0]        kind_r;
  logic signed [ols_pkg::DATA_W-1:0] val_r;
  logic [ols_pkg::POS_W-1:0]         pos_r;
  ols_pkg::status_e_t                status_r;
  logic signed [ols_pkg::DATA_W-1:0] rd_r;

  logic [IW-1:0]                     rd_idx;
  logic signed [ols_pkg::DATA_W-1:0] cur;
  logic [CAPACITY-2:0]               swp;
  logic [PW-1:0]                     pos_ext;
  logic [PW-1:0]                     count_ext;
  logic [XW-1:0]                     count_x;
  logic [XW-1:0]                     removed_x;

  // single read port: the scan pointer, or the position for read and write
  always_comb begin
    rd_idx = (ptr_r < CW'(CAPACITY)) ? ptr_r[IW-1:0] : '0;
    cur    = cells_r[rd_idx];
  end

  // odd-even transposition: pair (i, i+1) is live when i matches the round parity
  always_comb begin
    for (int i = 0; i < CAPACITY - 1; i++) begin
      swp[i] = (1'(i) == ptr_r[0]) && (CW'(i + 1) < count_r) && (cells_r[i] > cells_r[i + 1]);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
      if (cmd.append && (count_r == CW'(i))) begin
        cells_nxt[i] = val_r;
      end
      if ((cmd.write || cmd.insert) && (ptr_r == CW'(i))) begin
        cells_nxt[i] = val_r;
      end
    end
    // open a gap at the pointer
    for (int i = 1; i < CAPACITY; i++) begin
      if (cmd.insert && (ptr_r < CW'(i))) begin
        cells_nxt[i] = cells_r[i - 1];
      end
    end
    // close the gap at the pointer
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (cmd.remove && (ptr_r <= CW'(i))) begin
        cells_nxt[i] = cells_r[i + 1];
      end
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      if (cmd.sort_step && swp[i]) begin
        cells_nxt[i]     = cells_r[i + 1];
        cells_nxt[i + 1] = cells_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.append || cmd.insert) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.remove) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      val_r     <= in_value;
      pos_r     <= in_position;
      ptr_r     <= CW'(in_position);
      status_r  <= ols_pkg::STAT_OK;
      rd_r      <= '0;
      removed_r <= '0;
    end
    if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end
    if (cmd.ptr_inc || cmd.sort_step) begin
      ptr_r <= ptr_r + 1'b1;
    end
    if (cmd.remove) begin
      removed_r <= removed_r + 1'b1;
    end
    if (cmd.read) begin
      rd_r <= cur;
    end
    if (cmd.set_full) begin
      status_r <= ols_pkg::STAT_FULL;
    end
    if (cmd.set_not_found) begin
      status_r <= ols_pkg::STAT_NOT_FOUND;
    end
    if (cmd.set_bad) begin
      status_r <= ols_pkg::STAT_BAD_INDEX;
    end
  end

  always_comb begin
    pos_ext         = PW'(pos_r);
    count_ext       = PW'(count_r);
    st.kind         = kind_r;
    st.full         = count_r >= CW'(CAPACITY);
    st.at_end       = ptr_r >= count_r;
    st.hit_gt       = cur > val_r;
    st.hit_eq       = cur == val_r;
    st.bad_pos      = pos_ext >= count_ext;
    st.none_removed = removed_r == '0;
  end

  always_comb begin
    count_x           = XW'(count_r);
    removed_x         = XW'(removed_r);
    out_status        = status_r;
    out_read_value    = rd_r;
    out_entry_count   = count_x[ols_pkg::CNT_OUT_W-1:0];
    out_removed_count = removed_x[ols_pkg::CNT_OUT_W-1:0];
  end

  `OLS_ASSERT_NXT(a_remove_shrinks, clk, rst_n, cmd.remove, count_r == $past(count_r) - 1'b1, "remove did not shrink the list by one")
  `OLS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY), "entry count beyond capacity")

endmodule

// ===== hdl/ols_ctrl.sv =====
`include "ordered_list_store_assert.svh"

module ols_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  input  ols_pkg::dp_status_t st,
  output ols_pkg::dp_cmd_t    cmd
);

  ols_pkg::state_t state_r;
  ols_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ols_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ols_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = ols_pkg::S_EXEC;
        end
      end
      ols_pkg::S_EXEC: begin
        unique case (st.kind)
          ols_pkg::K_INSERT: begin
            state_nxt = st.full ? ols_pkg::S_DONE : ols_pkg::S_FIND;
          end
          ols_pkg::K_DEL_FIRST: state_nxt = ols_pkg::S_FIND;
          ols_pkg::K_DEL_ALL:   state_nxt = ols_pkg::S_PURGE;
          ols_pkg::K_SORT:      state_nxt = ols_pkg::S_SORT;
          default:              state_nxt = ols_pkg::S_DONE;
        endcase
      end
      ols_pkg::S_FIND: begin
        if (st.at_end
            || ((st.kind == ols_pkg::K_INSERT) && st.hit_gt)
            || ((st.kind == ols_pkg::K_DEL_FIRST) && st.hit_eq)) begin
          state_nxt = ols_pkg::S_DONE;
        end
      end
      ols_pkg::S_PURGE: begin
        if (st.at_end) begin
          state_nxt = ols_pkg::S_DONE;
        end
      end
      ols_pkg::S_SORT: begin
        if (st.at_end) begin
          state_nxt = ols_pkg::S_DONE;
        end
      end
      ols_pkg::S_DONE: state_nxt = ols_pkg::S_IDLE;
      default:         state_nxt = ols_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ols_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ols_pkg::S_EXEC: begin
        unique case (st.kind) inside
          ols_pkg::K_APPEND: begin
            cmd.set_full = st.full;
            cmd.append   = !st.full;
          end
          ols_pkg::K_INSERT: begin
            cmd.set_full = st.full;
            cmd.ptr_clr  = !st.full;
          end
          ols_pkg::K_DEL_FIRST, ols_pkg::K_DEL_ALL, ols_pkg::K_SORT: begin
            cmd.ptr_clr = 1'b1;
          end
          ols_pkg::K_READ: begin
            cmd.set_bad = st.bad_pos;
            cmd.read    = !st.bad_pos;
          end
          ols_pkg::K_WRITE: begin
            cmd.set_bad = st.bad_pos;
            cmd.write   = !st.bad_pos;
          end
          default: ;
        endcase
      end
      ols_pkg::S_FIND: begin
        if (st.kind == ols_pkg::K_INSERT) begin
          // tail or first greater entry takes the new value
          if (st.at_end || st.hit_gt) begin
            cmd.insert = 1'b1;
          end else begin
            cmd.ptr_inc = 1'b1;
          end
        end else if (st.at_end) begin
          cmd.set_not_found = 1'b1;
        end else if (st.hit_eq) begin
          cmd.remove = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ols_pkg::S_PURGE: begin
        // pointer stays put after a removal, the next entry slides in
        if (st.at_end) begin
          cmd.set_not_found = st.none_removed;
        end else if (st.hit_eq) begin
          cmd.remove = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ols_pkg::S_SORT: begin
        cmd.sort_step = !st.at_end;
      end
      ols_pkg::S_DONE: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

  `OLS_ASSERT_NXT(a_busy_after_start, clk, rst_n, start && !busy, busy,
                  "accepted request did not raise busy")
  `OLS_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid && !busy,
                  "result strobe not a single cycle")
  `OLS_ASSERT_IMP(a_strobe_while_busy, clk, rst_n, out_valid, busy,
                  "result strobe while idle")
  `OLS_ASSERT_IMP(a_one_edit, clk, rst_n, 1'b1,
                  $onehot0({cmd.append, cmd.insert, cmd.remove, cmd.write, cmd.sort_step}),
                  "more than one list edit in a cycle")

endmodule

// ===== hdl/ordered_list_store.sv =====
// Bounded list of signed 32-bit values held in a chain of CAPACITY cells, one request at a
// time. A request is taken when start is high and busy is low; its single result appears on
// the out_ ports for exactly one cycle with out_valid high, and cannot be held off, so the
// receiver must take it then. Append, read at, write at and the unused kind need no scan;
// sorted insert into a list that is not full, delete first, delete all and sort walk a scan
// pointer over the cells from the head, one entry per cycle but held after a removal in
// delete all, and sort runs n odd-even transposition rounds, n being the entries held.
module ordered_list_store #(
  parameter int CAPACITY = ols_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ols_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [ols_pkg::DATA_W-1:0] in_value,
  input  logic [ols_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  output logic [ols_pkg::STATUS_W-1:0]      out_status,
  output logic signed [ols_pkg::DATA_W-1:0] out_read_value,
  output logic [ols_pkg::CNT_OUT_W-1:0]     out_entry_count,
  output logic [ols_pkg::CNT_OUT_W-1:0]     out_removed_count
);

  ols_pkg::dp_cmd_t    cmd;
  ols_pkg::dp_status_t st;

  ols_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  ols_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .in_position       (in_position),
    .cmd               (cmd),
    .st                (st),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_entry_count   (out_entry_count),
    .out_removed_count (out_removed_count)
  );

endmodule
